// ----- hw/rtl/fph_pkg.sv -----
// Package for the frame poll handshake block.
// Holds the transaction payload types, the block state type, status codes and ID limits.
// Used by every module of the block; depends on nothing.
package fph_pkg;

	localparam logic [7:0] IdLow = 8'd10;
	localparam logic [7:0] IdHigh = 8'd240;
	localparam logic [7:0] ReadHigh = 8'd120;
	localparam logic [7:0] WriteLow = 8'd121;
	localparam logic [3:0] WriteLen = 4'd8;
	localparam logic [7:0] VerifyFlag = 8'h01;
	localparam logic [15:0] TimeoutReset = 16'd100;

	typedef enum logic [2:0] {
		ST_SENT = 3'd0,
		ST_HANDLED = 3'd1,
		ST_OUT_OF_RANGE = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_IDLE = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		CFG_SLAVE_MODE = 8'd0,
		CFG_TIMEOUT_TICKS = 8'd1
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] rx_id;
		logic [63:0] rx_data;
		logic [7:0] frame_id;
		logic [3:0] frame_length;
		logic [63:0] frame_data;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic record_updated;
		logic [63:0] new_record_data;
		logic tx_valid;
		logic [7:0] tx_id;
		logic [3:0] tx_length;
		logic [63:0] tx_data;
	} out_item_t;

	typedef struct packed {
		logic bus_free;
		logic [7:0] pending_id;
		logic [63:0] rx_store;
		logic [31:0] request_time;
		logic first_reply;
	} state_t;

	typedef struct packed {
		logic slave_mode;
		logic [15:0] timeout_ticks;
	} cfg_t;

endpackage

// ----- hw/rtl/fph_step.sv -----
// Next-state and result logic for one record transaction.
// Purely combinational; depends on fph_pkg for the item, state and config types.
module fph_step (
	input fph_pkg::in_item_t item,
	input fph_pkg::state_t st,
	input fph_pkg::cfg_t cfg,
	output fph_pkg::state_t nx,
	output fph_pkg::out_item_t res
);

	always_comb begin
		logic rx_hit;
		logic [7:0] pend;
		logic [63:0] store;
		logic [31:0] elapsed;

		rx_hit = (item.rx_id >= fph_pkg::IdLow) && (item.rx_id <= fph_pkg::IdHigh);
		pend = rx_hit ? item.rx_id : st.pending_id;
		store = rx_hit ? item.rx_data : st.rx_store;
		elapsed = item.now_ms - st.request_time;

		nx.bus_free = st.bus_free;
		nx.pending_id = pend;
		nx.rx_store = store;
		nx.request_time = st.request_time;
		nx.first_reply = st.first_reply;

		res = '0;
		res.status = fph_pkg::ST_IDLE;

		if (!cfg.slave_mode) begin
			if ((pend == item.frame_id) && !st.bus_free) begin
				res.record_updated = 1'b1;
				res.new_record_data = store;
				res.status = fph_pkg::ST_HANDLED;
				nx.bus_free = 1'b1;
				nx.pending_id = '0;
			end else if (st.bus_free) begin
				if ((item.frame_id >= fph_pkg::IdLow) && (item.frame_id <= fph_pkg::ReadHigh)) begin
					res.tx_valid = 1'b1;
					res.tx_id = item.frame_id;
					res.tx_length = item.frame_length;
					res.status = fph_pkg::ST_SENT;
					nx.bus_free = 1'b0;
					nx.request_time = item.now_ms;
				end else if ((item.frame_id >= fph_pkg::WriteLow) &&
						(item.frame_id <= fph_pkg::IdHigh)) begin
					res.tx_valid = 1'b1;
					res.tx_id = item.frame_id;
					res.tx_length = fph_pkg::WriteLen;
					res.tx_data = {fph_pkg::VerifyFlag, item.frame_data[55:0]};
					res.status = fph_pkg::ST_SENT;
					nx.bus_free = 1'b0;
					nx.request_time = item.now_ms;
				end else begin
					res.status = fph_pkg::ST_OUT_OF_RANGE;
				end
			end else if (elapsed > {16'd0, cfg.timeout_ticks}) begin
				res.status = fph_pkg::ST_TIMEOUT;
				nx.bus_free = 1'b1;
			end
		end else if (pend == item.frame_id) begin
			res.tx_valid = 1'b1;
			res.tx_id = item.frame_id;
			res.tx_length = item.frame_length;
			res.tx_data = item.frame_data;
			if (pend > fph_pkg::ReadHigh) begin
				if (st.first_reply) begin
					nx.first_reply = 1'b0;
				end else if (store[63:56] == fph_pkg::VerifyFlag) begin
					nx.rx_store = {8'd0, store[55:0]};
					res.record_updated = 1'b1;
					res.new_record_data = {8'd0, store[55:0]};
					res.tx_data = {8'd0, store[55:0]};
				end
			end
			nx.pending_id = '0;
			res.status = fph_pkg::ST_HANDLED;
		end
	end

endmodule

// ----- hw/rtl/frame_poll_handshake.sv -----
// Top level of the frame poll handshake block: input register, step logic, result register.
// Depends on fph_pkg and fph_step.
//
//   channel | direction | payload                  | handshake
//   in      | sink      | fph_pkg::in_item_t       | in_valid / in_ready
//   out     | source    | fph_pkg::out_item_t      | out_valid / out_ready
//   cfg     | sink      | cfg_index, cfg_data      | cfg_valid / cfg_ready
//
// Every transaction produces one result, shown once the input register hands it to the result
// register; one is taken per cycle unless the output stalls. The block state is updated in the
// cycle the input register hands its transaction to the result register. A stall on the output
// holds both registers; the input side is still taken while the input register is free.
// Reset sets bus_free and first_reply, clears the rest, timeout_ticks = 100, slave_mode = 0.
module frame_poll_handshake (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fph_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output fph_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [15:0] cfg_data
);

	fph_pkg::in_item_t item_s1;
	logic valid_s1;
	fph_pkg::out_item_t res_s2;
	logic valid_s2;
	fph_pkg::state_t state_q;
	fph_pkg::state_t state_nx;
	fph_pkg::cfg_t cfg_q;
	fph_pkg::out_item_t res;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_item = res_s2;

	fph_step u_step (
		.item(item_s1),
		.st(state_q),
		.cfg(cfg_q),
		.nx(state_nx),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.bus_free <= 1'b1;
			state_q.pending_id <= '0;
			state_q.rx_store <= '0;
			state_q.request_time <= '0;
			state_q.first_reply <= 1'b1;
			cfg_q.slave_mode <= 1'b0;
			cfg_q.timeout_ticks <= fph_pkg::TimeoutReset;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q <= state_nx;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					fph_pkg::CFG_SLAVE_MODE: begin
						cfg_q.slave_mode <= cfg_data[0];
					end
					fph_pkg::CFG_TIMEOUT_TICKS: begin
						cfg_q.timeout_ticks <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

endmodule

// ----- hw/rtl/fph_checker.sv -----
// Port-level checker for the frame poll handshake block, bound to its top level.
// Depends on fph_pkg for the result type and status codes.
module fph_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input fph_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("Stalled result transaction changed or dropped.");

	a_tx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.tx_valid |->
		out_item.tx_id == 8'd0 && out_item.tx_length == 4'd0 && out_item.tx_data == 64'd0)
		else $error("Transmit fields set without a transmitted frame.");

	a_update_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.record_updated |-> out_item.new_record_data == 64'd0)
		else $error("Record data set without a record update.");

	a_update_handled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_updated |-> out_item.status == fph_pkg::ST_HANDLED)
		else $error("Record update with a status other than handled.");

	a_tx_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.tx_valid |->
		out_item.status == fph_pkg::ST_SENT || out_item.status == fph_pkg::ST_HANDLED)
		else $error("Frame transmitted with a status that sends nothing.");

endmodule

bind frame_poll_handshake fph_checker u_fph_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

// ----- tb/tb_frame_poll_handshake.sv -----
// Self-checking testbench for frame_poll_handshake: a queue-fed driver, a stalling receiver
// and a monitor that compares every result with a built-in prediction of the poll logic.
// Depends on fph_pkg and the frame_poll_handshake RTL.
module tb_frame_poll_handshake;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fph_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fph_pkg::out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	frame_poll_handshake u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block state and its registers.
	logic bus_idle = 1'b1;
	logic [7:0] polled_id = '0;
	logic [63:0] rx_latch = '0;
	logic [55:0] verify_low = '0;
	logic [31:0] request_ms = '0;
	logic first_answer = 1'b1;
	logic slave_sh = 1'b0;
	logic [15:0] timeout_sh = fph_pkg::TimeoutReset;

	fph_pkg::in_item_t record_backlog[$];
	fph_pkg::out_item_t predicted_replies[$];
	int mismatch_count = 0;
	int queued_count = 0;
	logic [31:0] ms_clock = '0;

	bit sender_gappy = 1'b1;
	int ready_pct = 100;
	bit long_hold_arm = 1'b0;
	bit long_hold_done;
	int hold_left;
	int stall_left;
	int burst_left;
	int gap_left;

	function automatic fph_pkg::out_item_t predict_poll(fph_pkg::in_item_t it);
		fph_pkg::out_item_t r;
		logic [31:0] elapsed;
		r = '0;
		r.status = fph_pkg::ST_IDLE;
		if (it.rx_id >= fph_pkg::IdLow && it.rx_id <= fph_pkg::IdHigh) begin
			polled_id = it.rx_id;
			rx_latch = it.rx_data;
		end
		if (!slave_sh) begin
			if (polled_id == it.frame_id && !bus_idle) begin
				r.status = fph_pkg::ST_HANDLED;
				r.record_updated = 1'b1;
				r.new_record_data = rx_latch;
				bus_idle = 1'b1;
				polled_id = '0;
			end else if (bus_idle) begin
				if (it.frame_id >= fph_pkg::IdLow && it.frame_id <= fph_pkg::ReadHigh) begin
					r.status = fph_pkg::ST_SENT;
					r.tx_valid = 1'b1;
					r.tx_id = it.frame_id;
					r.tx_length = it.frame_length;
					bus_idle = 1'b0;
					request_ms = it.now_ms;
				end else if (it.frame_id >= fph_pkg::WriteLow &&
						it.frame_id <= fph_pkg::IdHigh) begin
					verify_low = it.frame_data[55:0];
					r.status = fph_pkg::ST_SENT;
					r.tx_valid = 1'b1;
					r.tx_id = it.frame_id;
					r.tx_length = fph_pkg::WriteLen;
					r.tx_data = {fph_pkg::VerifyFlag, verify_low};
					bus_idle = 1'b0;
					request_ms = it.now_ms;
				end else begin
					r.status = fph_pkg::ST_OUT_OF_RANGE;
				end
			end else begin
				elapsed = it.now_ms - request_ms;
				if (elapsed > {16'd0, timeout_sh}) begin
					bus_idle = 1'b1;
					r.status = fph_pkg::ST_TIMEOUT;
				end
			end
		end else if (polled_id == it.frame_id) begin
			r.status = fph_pkg::ST_HANDLED;
			r.tx_valid = 1'b1;
			r.tx_id = it.frame_id;
			r.tx_length = it.frame_length;
			r.tx_data = it.frame_data;
			if (polled_id > fph_pkg::ReadHigh) begin
				if (first_answer) begin
					first_answer = 1'b0;
				end else if (rx_latch[63:56] == fph_pkg::VerifyFlag) begin
					rx_latch[63:56] = 8'd0;
					r.record_updated = 1'b1;
					r.new_record_data = {8'd0, rx_latch[55:0]};
					r.tx_data = rx_latch;
				end
			end
			polled_id = '0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			flag_mismatch(what, got, want);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				predicted_replies.push_back(predict_poll(in_item));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (record_backlog.size() != 0) begin
					in_item <= record_backlog.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= sender_gappy ? $urandom_range(1, 8) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_arm && !long_hold_done) begin
			hold_left <= 400;
			long_hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) >= ready_pct)
				stall_left <= $urandom_range(1, 6);
		end
	end

	always @(posedge clk) begin
		fph_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_replies.size() == 0) begin
				flag_mismatch("result with nothing outstanding, status",
					64'(out_item.status), '0);
			end else begin
				want = predicted_replies.pop_front();
				check_field("status", 64'(out_item.status), 64'(want.status));
				check_field("record_updated", 64'(out_item.record_updated),
					64'(want.record_updated));
				check_field("new_record_data", out_item.new_record_data, want.new_record_data);
				check_field("tx_valid", 64'(out_item.tx_valid), 64'(want.tx_valid));
				check_field("tx_id", 64'(out_item.tx_id), 64'(want.tx_id));
				check_field("tx_length", 64'(out_item.tx_length), 64'(want.tx_length));
				check_field("tx_data", out_item.tx_data, want.tx_data);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] no_frame_id();
		return $urandom_range(0, 1) ? 8'($urandom_range(0, fph_pkg::IdLow - 1)) :
			8'($urandom_range(fph_pkg::IdHigh + 1, 255));
	endfunction

	function automatic logic [7:0] record_id();
		case ($urandom_range(0, 9))
			0: return fph_pkg::IdLow;
			1: return fph_pkg::IdHigh;
			2: return fph_pkg::ReadHigh;
			3: return fph_pkg::WriteLow;
			default: return 8'($urandom_range(fph_pkg::IdLow, fph_pkg::IdHigh));
		endcase
	endfunction

	function automatic logic [7:0] other_id();
		return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [3:0] rand_len();
		return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 8));
	endfunction

	task automatic queue_record(logic [7:0] rid, logic [63:0] rdata, logic [7:0] fid,
			logic [3:0] flen, logic [63:0] fdata, logic [31:0] now);
		fph_pkg::in_item_t it;
		it.rx_id = rid;
		it.rx_data = rdata;
		it.frame_id = fid;
		it.frame_length = flen;
		it.frame_data = fdata;
		it.now_ms = now;
		record_backlog.push_back(it);
		queued_count++;
	endtask

	function automatic logic [31:0] tick();
		ms_clock += $urandom_range(0, 30);
		return ms_clock;
	endfunction

	task automatic queue_master_poll();
		logic [7:0] id;
		logic [31:0] sent_ms;
		id = record_id();
		sent_ms = tick();
		queue_record(no_frame_id(), rand64(), id, rand_len(), rand64(), sent_ms);
		repeat ($urandom_range(0, 2))
			queue_record(no_frame_id(), rand64(), other_id(), rand_len(), rand64(), tick());
		case ($urandom_range(0, 5))
			0: begin
				ms_clock = sent_ms + timeout_sh + $urandom_range(0, 1);
				queue_record(no_frame_id(), rand64(), other_id(), rand_len(), rand64(), ms_clock);
			end
			1: begin
				queue_record(id, rand64(), other_id(), rand_len(), rand64(), tick());
				queue_record(no_frame_id(), rand64(), id, rand_len(), rand64(), tick());
			end
			default: queue_record(id, rand64(), id, rand_len(), rand64(), tick());
		endcase
	endtask

	task automatic queue_slave_answer();
		logic [7:0] id;
		logic [63:0] data;
		id = record_id();
		data = rand64();
		if (id > fph_pkg::ReadHigh && $urandom_range(0, 3) != 0)
			data[63:56] = fph_pkg::VerifyFlag;
		if ($urandom_range(0, 4) == 0) begin
			queue_record(id, data, other_id(), rand_len(), rand64(), tick());
			queue_record(no_frame_id(), rand64(), id, rand_len(), rand64(), tick());
		end else begin
			queue_record(id, data, id, rand_len(), rand64(), tick());
		end
	endtask

	task automatic queue_random(int count);
		int target;
		target = queued_count + count;
		while (queued_count < target) begin
			if ($urandom_range(0, 99) < 12)
				queue_record(8'($urandom), rand64(), 8'($urandom), 4'($urandom), rand64(),
					$urandom);
			else if (slave_sh)
				queue_slave_answer();
			else
				queue_master_poll();
		end
	endtask

	task automatic settle();
		do @(posedge clk);
		while (record_backlog.size() != 0 || in_valid || predicted_replies.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(fph_pkg::cfg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == fph_pkg::CFG_SLAVE_MODE)
			slave_sh = val[0];
		else
			timeout_sh = val;
	endtask

	task automatic run_phase(logic [15:0] mode, logic [15:0] ticks, logic [31:0] start_ms,
			int count, int pct, bit gappy);
		write_reg(fph_pkg::CFG_SLAVE_MODE, mode);
		write_reg(fph_pkg::CFG_TIMEOUT_TICKS, ticks);
		ms_clock = start_ms;
		ready_pct = pct;
		sender_gappy = gappy;
		queue_random(count);
		settle();
	endtask

	initial begin
		int drain_cycles;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		ready_pct = 80;
		queue_record(8'd0, '0, 8'd0, 4'd0, '0, 32'd0);
		queue_record(8'd255, '1, 8'd255, 4'd15, '1, 32'hFFFF_FFFF);
		queue_record(8'd0, '0, fph_pkg::IdLow, 4'd0, '1, 32'd0);
		queue_record(8'd0, '0, 8'd0, 4'd0, '0, 32'd5);
		queue_record(fph_pkg::IdLow - 8'd1, '1, fph_pkg::ReadHigh, 4'd15, '1, 32'hFFFF_FFF0);
		queue_record(fph_pkg::ReadHigh, '1, fph_pkg::WriteLow, 4'd3, '0, 32'd0);
		queue_record(fph_pkg::IdHigh + 8'd1, '0, fph_pkg::ReadHigh, 4'd2, '0, 32'd1);
		queue_record(8'd0, '0, fph_pkg::IdHigh, 4'd1, '1, 32'd1000);
		queue_record(8'd0, '0, 8'd7, 4'd0, '0, 32'd1100);
		queue_record(8'd0, '0, 8'd7, 4'd0, '0, 32'd1101);
		queue_record(8'd0, '0, fph_pkg::WriteLow, 4'd8, 64'h0123_4567_89AB_CDEF, 32'd2000);
		queue_record(fph_pkg::WriteLow, 64'hFEDC_BA98_7654_3210, fph_pkg::WriteLow, 4'd8, '0,
			32'd2001);
		queue_record(fph_pkg::IdLow, 64'h5555_5555_5555_5555, fph_pkg::IdLow, 4'd4,
			64'hAAAA_AAAA_AAAA_AAAA, 32'd3000);
		queue_record(8'd0, '0, fph_pkg::IdLow, 4'd4, '0, 32'd3001);
		settle();

		write_reg(fph_pkg::CFG_SLAVE_MODE, 16'd1);
		queue_record(8'd0, '0, 8'd0, 4'd5, 64'h1111_2222_3333_4444, 32'd0);
		queue_record(8'd200, 64'h01AA_BBCC_DDEE_FF00, 8'd200, 4'd8, 64'h7777_6666_5555_4444,
			32'd0);
		queue_record(8'd200, 64'h0102_0304_0506_0708, 8'd200, 4'd8, 64'h8888_9999_AAAA_BBBB,
			32'd0);
		queue_record(fph_pkg::IdHigh, 64'h0200_0000_0000_00FF, fph_pkg::IdHigh, 4'd8, '1,
			32'd0);
		queue_record(8'd50, 64'h0100_0000_0000_0001, 8'd50, 4'd12, 64'hDEAD_BEEF_0BAD_F00D,
			32'd0);
		queue_record(8'd60, '1, 8'd61, 4'd1, '1, 32'd0);
		queue_record(8'd0, '0, 8'd60, 4'd7, 64'h0F0F_0F0F_0F0F_0F0F, 32'd0);
		queue_record(fph_pkg::IdHigh, 64'h01FF_FFFF_FFFF_FFFF, fph_pkg::IdHigh, 4'd15, '0,
			32'd0);
		settle();

		run_phase(16'hFFFE, 16'd100, 32'd1000, 280, 70, 1'b1);
		long_hold_arm = 1'b1;
		run_phase(16'd0, 16'd0, $urandom, 200, 100, 1'b0);
		run_phase(16'd0, 16'hFFFF, 32'hFFFF_0000, 220, 100, 1'b0);
		run_phase(16'd1, 16'd100, $urandom, 300, 50, 1'b1);
		run_phase(16'd0, 16'($urandom_range(1, 300)), $urandom, 250, 85, 1'b1);
		run_phase(16'd1, 16'd1, $urandom, 150, 40, 1'b1);
		run_phase(16'd0, 16'd20, 32'hFFFF_FFF0, 130, 60, 1'b1);

		drain_cycles = 0;
		while (predicted_replies.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (predicted_replies.size() != 0)
			flag_mismatch("results never delivered, count", 64'(predicted_replies.size()), '0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("run timed out");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
